@@ src/http_request_line_check_defines.svh @@
// ----------------------------------------------------------------------------
// HTTP request line check: assertion macros
// Shared concurrent assertion wrappers for the request line checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_CHECK_DEFINES_SVH
`define HTTP_REQUEST_LINE_CHECK_DEFINES_SVH

// Check on every clock edge outside reset.
`define HRLC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define HRLC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/hrlc_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP request line check: package
// Method and version tables, reason codes and the verdict type.
// ----------------------------------------------------------------------------
package hrlc_pkg;

	localparam int METHOD_COUNT = 9;
	localparam logic [3:0] METHOD_MAX_LEN = 4'd8;
	localparam logic [3:0] VERSION_LEN = 4'd8;

	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [1:0] REASON_PASS = 2'd0;
	localparam logic [1:0] REASON_NO_METHOD = 2'd1;
	localparam logic [1:0] REASON_NO_LINE_END = 2'd2;
	localparam logic [1:0] REASON_NO_VERSION = 2'd3;

	typedef struct packed {
		logic is_request;
		logic [1:0] fail_reason;
	} hrlc_verdict_t;

	// Method names, left aligned, zero padded to eight bytes.
	function automatic logic [7:0] method_char(input logic [3:0] m, input logic [2:0] p);
		logic [63:0] s;
		unique case (m)
			4'd0: s = {"GET ", 32'h0};
			4'd1: s = {"POST ", 24'h0};
			4'd2: s = {"PUT ", 32'h0};
			4'd3: s = {"DELETE ", 8'h0};
			4'd4: s = {"HEAD ", 24'h0};
			4'd5: s = "OPTIONS ";
			4'd6: s = {"PATCH ", 16'h0};
			4'd7: s = {"TRACE ", 16'h0};
			4'd8: s = "CONNECT ";
			default: s = 64'h0;
		endcase
		return s[(7 - int'(p)) * 8 +: 8];
	endfunction

	// Length of each method name, trailing space included.
	function automatic logic [3:0] method_len(input logic [3:0] m);
		logic [3:0] n;
		unique case (m)
			4'd0: n = 4'd4;
			4'd1: n = 4'd5;
			4'd2: n = 4'd4;
			4'd3: n = 4'd7;
			4'd4: n = 4'd5;
			4'd5: n = 4'd8;
			4'd6: n = 4'd6;
			4'd7: n = 4'd6;
			4'd8: n = 4'd8;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// " HTTP/1." one character at a time.
	function automatic logic [7:0] version_char(input logic [2:0] p);
		logic [63:0] s;
		s = " HTTP/1.";
		return s[(7 - int'(p)) * 8 +: 8];
	endfunction

endpackage

@@ src/http_request_line_check.sv @@
// ----------------------------------------------------------------------------
// HTTP request line check: top level
// Checks a byte stream for an HTTP request line, one byte per cycle unless a verdict waits for the receiver.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one message byte per
//   transaction in data_byte, with last_byte high on the final byte.
//   A zero byte ends the string; later bytes up to last_byte are ignored.
//   Output channel (out_valid / out_ready) carries one transaction per
//   message, produced only for the byte flagged last: is_request and
//   fail_reason (0 pass, 1 no method, 2 no CR LF, 3 no version before CR LF).
//   Throughput: one byte per cycle while no verdict waits for the receiver;
//   the scanner updates its match state once for every byte that advances.
//   The last byte passes through the input register; its verdict is then
//   loaded into the result register, which drives out_valid, once that
//   register is free.
//   Reset clears the valid flags of both registers and the match state; the
//   block is ready for a byte as soon as reset is released.
//   When the receiver stalls, the verdict holds in the output register;
//   non-last bytes keep flowing, and a new last byte waits in the input
//   register until the output register frees up.
// ----------------------------------------------------------------------------
`include "http_request_line_check_defines.svh"

module http_request_line_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_request,
	output logic [1:0] fail_reason
);

	// input register
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       last_byte_s1;

	// result register
	logic       out_valid_q;
	logic       is_request_q;
	logic [1:0] fail_reason_q;

	logic out_free;
	logic advance_s1;
	hrlc_pkg::hrlc_verdict_t verdict;

	// A byte leaves the input register unless it carries a verdict that
	// has nowhere to go yet.
	assign out_free   = !out_valid_q || out_ready;
	assign advance_s1 = valid_s1 && (!last_byte_s1 || out_free);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold the payload until a new transaction lands
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_byte_s1 <= data_byte;
			last_byte_s1 <= last_byte;
		end
	end

	hrlc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance_s1),
		.data_byte (data_byte_s1),
		.last_byte (last_byte_s1),
		.verdict   (verdict)
	);

	// Load the verdict on the last byte, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_byte_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_byte_s1) begin
			is_request_q  <= verdict.is_request;
			fail_reason_q <= verdict.fail_reason;
		end
	end

	assign out_valid   = out_valid_q;
	assign is_request  = is_request_q;
	assign fail_reason = fail_reason_q;

	`HRLC_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid_q && !valid_s1, "registers not empty in reset")
	`HRLC_ASSERT(a_verdict_code, out_valid_q |-> is_request_q == (fail_reason_q == hrlc_pkg::REASON_PASS), "verdict flag disagrees with reason")
	`HRLC_ASSERT(a_out_hold, out_valid_q && !out_ready |=> out_valid_q && $stable(is_request_q) && $stable(fail_reason_q), "verdict changed while stalled")

endmodule

@@ src/hrlc_scan.sv @@
// ----------------------------------------------------------------------------
// HTTP request line check: byte scanner
// Holds the match state, advances it by one byte a step and gives the verdict.
// ----------------------------------------------------------------------------
`include "http_request_line_check_defines.svh"

module hrlc_scan (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	output hrlc_pkg::hrlc_verdict_t verdict
);

	logic [hrlc_pkg::METHOD_COUNT-1:0] methods_alive_q, methods_alive_d;
	logic [3:0] byte_position_q, byte_position_d;
	logic method_matched_q, method_matched_d;
	logic [3:0] version_progress_q, version_progress_d;
	logic version_found_q, version_found_d;
	logic previous_was_cr_q, previous_was_cr_d;
	logic line_end_found_q, line_end_found_d;
	logic string_ended_q, string_ended_d;

	always_comb begin
		methods_alive_d = methods_alive_q;
		byte_position_d = byte_position_q;
		method_matched_d = method_matched_q;
		version_progress_d = version_progress_q;
		version_found_d = version_found_q;
		previous_was_cr_d = previous_was_cr_q;
		line_end_found_d = line_end_found_q;
		string_ended_d = string_ended_q;

		if (step && !string_ended_q) begin
			if (data_byte == hrlc_pkg::CHAR_NUL) begin
				string_ended_d = 1'b1;
			end else begin
				// method prefixes, stop once one matched or past the longest
				if (!method_matched_q && byte_position_q < hrlc_pkg::METHOD_MAX_LEN) begin
					for (int i = 0; i < hrlc_pkg::METHOD_COUNT; i++) begin
						if (methods_alive_q[i]) begin
							if (byte_position_q >= hrlc_pkg::method_len(4'(i)) ||
							    hrlc_pkg::method_char(4'(i), byte_position_q[2:0]) != data_byte) begin
								methods_alive_d[i] = 1'b0;
							end else if (byte_position_q + 4'd1 == hrlc_pkg::method_len(4'(i))) begin
								method_matched_d = 1'b1;
							end
						end
					end
					byte_position_d = byte_position_q + 4'd1;
				end
				// version text, only before the first line end
				if (!version_found_q && !line_end_found_q) begin
					if (version_progress_q < hrlc_pkg::VERSION_LEN &&
					    hrlc_pkg::version_char(version_progress_q[2:0]) == data_byte) begin
						version_progress_d = version_progress_q + 4'd1;
						if (version_progress_q + 4'd1 == hrlc_pkg::VERSION_LEN) begin
							version_found_d = 1'b1;
						end
					end else begin
						version_progress_d = (data_byte == hrlc_pkg::CHAR_SPACE) ? 4'd1 : 4'd0;
					end
				end
				// CR LF detector
				if (previous_was_cr_q && data_byte == hrlc_pkg::CHAR_LF) begin
					line_end_found_d = 1'b1;
				end
				previous_was_cr_d = (data_byte == hrlc_pkg::CHAR_CR);
			end
		end

		// first failed check wins
		priority if (!method_matched_d) begin
			verdict.fail_reason = hrlc_pkg::REASON_NO_METHOD;
		end else if (!line_end_found_d) begin
			verdict.fail_reason = hrlc_pkg::REASON_NO_LINE_END;
		end else if (!version_found_d) begin
			verdict.fail_reason = hrlc_pkg::REASON_NO_VERSION;
		end else begin
			verdict.fail_reason = hrlc_pkg::REASON_PASS;
		end
		verdict.is_request = (verdict.fail_reason == hrlc_pkg::REASON_PASS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			methods_alive_q <= '1;
			byte_position_q <= '0;
			method_matched_q <= 1'b0;
			version_progress_q <= '0;
			version_found_q <= 1'b0;
			previous_was_cr_q <= 1'b0;
			line_end_found_q <= 1'b0;
			string_ended_q <= 1'b0;
		end else if (step && last_byte) begin
			// verdict given: start over for the next message
			methods_alive_q <= '1;
			byte_position_q <= '0;
			method_matched_q <= 1'b0;
			version_progress_q <= '0;
			version_found_q <= 1'b0;
			previous_was_cr_q <= 1'b0;
			line_end_found_q <= 1'b0;
			string_ended_q <= 1'b0;
		end else begin
			methods_alive_q <= methods_alive_d;
			byte_position_q <= byte_position_d;
			method_matched_q <= method_matched_d;
			version_progress_q <= version_progress_d;
			version_found_q <= version_found_d;
			previous_was_cr_q <= previous_was_cr_d;
			line_end_found_q <= line_end_found_d;
			string_ended_q <= string_ended_d;
		end
	end

	`HRLC_ASSERT(a_restart_after_last, step && last_byte |=> methods_alive_q == '1 && byte_position_q == 4'd0 && !method_matched_q && !string_ended_q, "scan state not cleared after last byte")
	`HRLC_ASSERT(a_version_full, version_found_q |-> version_progress_q == hrlc_pkg::VERSION_LEN, "version found without full match")
	`HRLC_ASSERT(a_method_alive, method_matched_q |-> methods_alive_q != '0, "method matched with no method alive")

endmodule
